### hw/rtl/ptc_pkg.sv
// Package for the pressure and temperature compensation block.
// Holds the shared constants, the queue entry type and small arithmetic helpers.
// No dependencies.
package ptc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_STAGES  = 64;
  localparam int POST_STAGES = 7;

  // Configuration register indexes.
  localparam logic [1:0] REG_TEMP_CAL    = 2'd0;
  localparam logic [1:0] REG_PRESS_CAL_A = 2'd1;
  localparam logic [1:0] REG_PRESS_CAL_B = 2'd2;
  localparam logic [1:0] REG_PRESS_CAL_C = 2'd3;

  // Compensation constants.
  localparam logic [33:0] FINE_OFFSET = 34'd128000;
  localparam logic [20:0] FULL_SCALE  = 21'd1048576;
  localparam logic [16:0] PRESS_SCALE = 17'd3125;
  localparam logic [31:0] TEMP_ROUND  = 32'd128;
  localparam logic [31:0] TEMP_MULT   = 32'd5;
  localparam logic [63:0] NORM_BIAS   = 64'h0000_8000_0000_0000;

  // One compensated record waiting for its pressure division.
  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] fine;
    logic [63:0] num;
    logic [63:0] den;
    logic        invalid;
  } entry_t;

  // Fields that ride along with the divider and post stages.
  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] fine;
    logic        invalid;
  } side_t;

  function automatic logic [63:0] sx16_64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Low partial of a 64 by 17 bit product modulo 2^64, sign extended.
  function automatic logic [63:0] mul17_lo(input logic [63:0] a, input logic signed [16:0] b);
    logic signed [49:0] pr;
    pr = $signed({1'b0, a[31:0]}) * b;
    return {{14{pr[49]}}, pr};
  endfunction

  // High partial of a 64 by 17 bit product; only bits that land below 2^64 survive.
  function automatic logic [31:0] mul17_hi(input logic [63:0] a, input logic signed [16:0] b);
    logic signed [49:0] pr;
    pr = $signed({1'b0, a[63:32]}) * b;
    return pr[31:0];
  endfunction

endpackage

### hw/rtl/pressure_temp_compensation.sv
// Structure: 11 front stages, the queue and 72 back stages lie between the input transfer
// and the result transfer.
// Throughput: one record per cycle unless the output stalls; the divider is 64 stages deep.
// Reset clears all valid bits, the queue and the calibration registers to zero.
// Top level: configuration registers, front pipeline, queue and back pipeline.
// Depends on ptc_pkg, ptc_front, ptc_queue and ptc_back.
module pressure_temp_compensation #(
  parameter int QUEUE_DEPTH = ptc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pressure high, middle and extra byte, then temperature high, middle and extra byte
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // temperature, fine_temperature, pressure
  output logic [95:0] m_tdata,
  // pressure_invalid
  output logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ptc_pkg::*;

  logic [47:0] temp_cal;
  logic [63:0] press_cal_a, press_cal_b;
  logic [15:0] press_cal_c;

  logic   f_valid, f_ready, q_valid, q_ready;
  entry_t f_entry, q_entry;
  logic [31:0] temperature, fine_temperature, pressure;
  logic        pressure_invalid;

  // Calibration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal    <= '0;
      press_cal_a <= '0;
      press_cal_b <= '0;
      press_cal_c <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_CAL:    temp_cal    <= cfg_data[47:0];
        REG_PRESS_CAL_A: press_cal_a <= cfg_data;
        REG_PRESS_CAL_B: press_cal_b <= cfg_data;
        REG_PRESS_CAL_C: press_cal_c <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ptc_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .temp_cal, .press_cal_a, .press_cal_b,
    .out_valid(f_valid), .out_ready(f_ready), .out_entry(f_entry)
  );

  ptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_entry(f_entry),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_entry(q_entry)
  );

  ptc_back u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_entry(q_entry),
    .press_cal_b, .press_cal_c,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .temperature, .fine_temperature, .pressure, .pressure_invalid
  );

  assign m_tdata = {pressure, fine_temperature, temperature};
  assign m_tuser = pressure_invalid;

endmodule

### hw/rtl/ptc_front.sv
// Front pipeline: unpacks raw bytes, compensates temperature and prepares
// the pressure dividend and divisor. Depends on ptc_pkg.
module ptc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [47:0]         in_data,
  input  logic [47:0]         temp_cal,
  input  logic [63:0]         press_cal_a,
  input  logic [63:0]         press_cal_b,
  output logic                out_valid,
  input  logic                out_ready,
  output ptc_pkg::entry_t     out_entry
);
  import ptc_pkg::*;

  localparam int NST = 11;

  logic [NST:1] v;
  logic         adv;

  logic [19:0] adc_t, adc_p;
  logic [15:0] t1;
  logic signed [15:0] t2, t3;

  // Stage registers.
  logic [31:0] s1_ta;  logic signed [16:0] s1_d;  logic [19:0] s1_p;
  logic [31:0] s2_a, s2_dd;  logic [19:0] s2_p;
  logic [31:0] s3_a, s3_tb;  logic [19:0] s3_p;
  logic [31:0] s4_fine;  logic [19:0] s4_p;
  logic [31:0] s5_fine, s5_temp;  logic [33:0] s5_v1;  logic [19:0] s5_p;
  logic [31:0] s6_fine, s6_temp;  logic [63:0] s6_sq;  logic [49:0] s6_v5, s6_v2;
  logic [19:0] s6_p;
  logic [31:0] s7_fine, s7_temp;  logic [63:0] s7_l6, s7_l3;  logic [31:0] s7_h6, s7_h3;
  logic [49:0] s7_v5, s7_v2;  logic [19:0] s7_p;
  logic [31:0] s8_fine, s8_temp;  logic [63:0] s8_v2, s8_v1a;  logic [19:0] s8_p;
  logic [31:0] s9_fine, s9_temp;  logic [63:0] s9_x, s9_nb;
  logic [31:0] s10_fine, s10_temp;  logic [63:0] s10_lx, s10_ln;  logic [31:0] s10_hx, s10_hn;
  entry_t      s11;

  // Combinational helpers for each stage.
  logic [31:0] ta_x;
  logic signed [47:0] ta_p;
  logic signed [16:0] d_c;
  logic [31:0] a_sh;
  logic signed [33:0] dd_p;
  logic signed [31:0] dd_sh;
  logic signed [47:0] tb_p;
  logic [31:0] tb_sh;
  logic [31:0] t5, temp_c;
  logic signed [67:0] sq_p;
  logic signed [49:0] v5_p, v2_p;
  logic [63:0] sq3, sq3_sh, v2_c, v1a_c;
  logic [20:0] praw;
  logic [63:0] den_full, den_c, num_c;

  assign adc_p = {in_data[7:0], in_data[15:8], in_data[23:20]};
  assign adc_t = {in_data[31:24], in_data[39:32], in_data[47:44]};
  assign t1 = temp_cal[15:0];
  assign t2 = $signed(temp_cal[31:16]);
  assign t3 = $signed(temp_cal[47:32]);

  // The whole pipe moves when its last stage is empty or hands off.
  assign adv       = !v[NST] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v[NST];
  assign out_entry = s11;

  assign ta_x   = 32'(adc_t >> 3) - {15'd0, t1, 1'b0};
  assign ta_p   = $signed(ta_x) * t2;
  assign d_c    = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, t1});
  assign a_sh   = $signed(s1_ta) >>> 11;
  assign dd_p   = s1_d * s1_d;
  assign dd_sh  = $signed(s2_dd) >>> 12;
  assign tb_p   = dd_sh * t3;
  assign tb_sh  = $signed(s3_tb) >>> 14;
  assign t5     = s4_fine * TEMP_MULT + TEMP_ROUND;
  assign temp_c = $signed(t5) >>> 8;
  assign sq_p   = $signed(s5_v1) * $signed(s5_v1);
  assign v5_p   = $signed(s5_v1) * $signed(press_cal_b[15:0]);
  assign v2_p   = $signed(s5_v1) * $signed(press_cal_a[31:16]);
  assign sq3    = s7_l3 + {s7_h3, 32'd0};
  assign sq3_sh = $signed(sq3) >>> 8;
  assign v2_c   = s7_l6 + {s7_h6, 32'd0} + ({{14{s7_v5[49]}}, s7_v5} << 17)
                + (sx16_64(press_cal_a[63:48]) << 35);
  assign v1a_c  = sq3_sh + ({{14{s7_v2[49]}}, s7_v2} << 12);
  assign praw   = FULL_SCALE - {1'b0, s8_p};
  assign den_full = s10_lx + {s10_hx, 32'd0};
  assign den_c  = $signed(den_full) >>> 33;
  assign num_c  = s10_ln + {s10_hn, 32'd0};

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-1:1], in_valid};
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ta <= ta_p[31:0];
      s1_d  <= d_c;
      s1_p  <= adc_p;
      s2_a  <= a_sh;
      s2_dd <= dd_p[31:0];
      s2_p  <= s1_p;
      s3_a  <= s2_a;
      s3_tb <= tb_p[31:0];
      s3_p  <= s2_p;
      s4_fine <= s3_a + tb_sh;
      s4_p  <= s3_p;
      s5_fine <= s4_fine;
      s5_temp <= temp_c;
      s5_v1 <= {{2{s4_fine[31]}}, s4_fine} - FINE_OFFSET;
      s5_p  <= s4_p;
      s6_fine <= s5_fine;
      s6_temp <= s5_temp;
      s6_sq <= sq_p[63:0];
      s6_v5 <= v5_p;
      s6_v2 <= v2_p;
      s6_p  <= s5_p;
      s7_fine <= s6_fine;
      s7_temp <= s6_temp;
      s7_l6 <= mul17_lo(s6_sq, $signed({press_cal_b[31], press_cal_b[31:16]}));
      s7_h6 <= mul17_hi(s6_sq, $signed({press_cal_b[31], press_cal_b[31:16]}));
      s7_l3 <= mul17_lo(s6_sq, $signed({press_cal_a[47], press_cal_a[47:32]}));
      s7_h3 <= mul17_hi(s6_sq, $signed({press_cal_a[47], press_cal_a[47:32]}));
      s7_v5 <= s6_v5;
      s7_v2 <= s6_v2;
      s7_p  <= s6_p;
      s8_fine <= s7_fine;
      s8_temp <= s7_temp;
      s8_v2 <= v2_c;
      s8_v1a <= v1a_c;
      s8_p  <= s7_p;
      s9_fine <= s8_fine;
      s9_temp <= s8_temp;
      s9_x  <= NORM_BIAS + s8_v1a;
      s9_nb <= ({43'd0, praw} << 31) - s8_v2;
      s10_fine <= s9_fine;
      s10_temp <= s9_temp;
      s10_lx <= mul17_lo(s9_x, $signed({1'b0, press_cal_a[15:0]}));
      s10_hx <= mul17_hi(s9_x, $signed({1'b0, press_cal_a[15:0]}));
      s10_ln <= mul17_lo(s9_nb, $signed(PRESS_SCALE));
      s10_hn <= mul17_hi(s9_nb, $signed(PRESS_SCALE));
      s11.temperature <= s10_temp;
      s11.fine    <= s10_fine;
      s11.num     <= num_c;
      s11.den     <= den_c;
      s11.invalid <= (den_c == 64'd0);
    end
  end

endmodule

### hw/rtl/ptc_queue.sv
// Short register queue between the front and back pipelines.
// Depends on ptc_pkg for the entry type.
module ptc_queue #(
  parameter int DEPTH = ptc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  ptc_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ptc_pkg::entry_t pop_entry
);
  import ptc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + CW'($past(push)) - CW'($past(pop)))
    else $error("queue count does not follow transfers");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr)) else $error("empty queue with pointer gap");

endmodule

### hw/rtl/ptc_back.sv
// Back pipeline: signed 64-bit division one quotient bit per stage, then the
// final pressure terms and the output register. Depends on ptc_pkg.
module ptc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ptc_pkg::entry_t in_entry,
  input  logic [63:0]     press_cal_b,
  input  logic [15:0]     press_cal_c,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     temperature,
  output logic [31:0]     fine_temperature,
  output logic [31:0]     pressure,
  output logic            pressure_invalid
);
  import ptc_pkg::*;

  localparam int NV = DIV_STAGES + POST_STAGES + 1;

  logic [NV-1:0] v;
  logic          adv;

  // Divider stage registers; index 0 is the operand stage.
  logic [63:0] dr [DIV_STAGES+1];
  logic [63:0] dn [DIV_STAGES+1];
  logic [63:0] dd [DIV_STAGES+1];
  logic        dneg [DIV_STAGES+1];
  side_t       dside [DIV_STAGES+1];

  side_t       ps [1:POST_STAGES];
  logic [63:0] p1_q, p2_q, p2_x, p2_l8, p3_q, p3_x, p3_v2, p3_l9, p4_q, p4_v2, p4_m1, p4_x;
  logic [63:0] p5_q, p5_v2, p5_ll, p6_q, p6_v2, p6_m2;
  logic [31:0] p2_h8, p3_h9, p5_cr, p7_p;

  logic [63:0] x_c, v2s_c, m1_c, m2_c, m2_sh, v2_sh, sum_c, sum_sh, res_c;
  logic signed [16:0] p8_17, p9_17;

  assign adv       = !v[NV-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v[NV-1];

  assign p8_17 = $signed({press_cal_b[63], press_cal_b[63:48]});
  assign p9_17 = $signed({press_cal_c[15], press_cal_c});

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NV-2:0], in_valid};
    end
  end

  // Operand stage: magnitudes and quotient sign.
  always_ff @(posedge clk) begin
    if (adv) begin
      dr[0]   <= '0;
      dn[0]   <= in_entry.num[63] ? 64'd0 - in_entry.num : in_entry.num;
      dd[0]   <= in_entry.den[63] ? 64'd0 - in_entry.den : in_entry.den;
      dneg[0] <= in_entry.num[63] ^ in_entry.den[63];
      dside[0] <= '{temperature: in_entry.temperature, fine: in_entry.fine,
                    invalid: in_entry.invalid};
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [64:0] trial;
    logic        fit;
    assign trial = {dr[k-1], dn[k-1][63]};
    assign fit   = (trial >= {1'b0, dd[k-1]});
    always_ff @(posedge clk) begin
      if (adv) begin
        dr[k]    <= fit ? 64'(trial - {1'b0, dd[k-1]}) : trial[63:0];
        dn[k]    <= {dn[k-1][62:0], fit};
        dd[k]    <= dd[k-1];
        dneg[k]  <= dneg[k-1];
        dside[k] <= dside[k-1];
      end
    end
  end

  assign x_c    = $signed(p1_q) >>> 13;
  assign v2s_c  = p2_l8 + {p2_h8, 32'd0};
  assign m1_c   = p3_l9 + {p3_h9, 32'd0};
  assign m2_c   = p5_ll + {p5_cr, 32'd0};
  assign m2_sh  = $signed(p6_m2) >>> 25;
  assign v2_sh  = $signed(p6_v2) >>> 19;
  assign sum_c  = p6_q + m2_sh + v2_sh;
  assign sum_sh = $signed(sum_c) >>> 8;
  assign res_c  = sum_sh + (sx16_64(press_cal_b[47:32]) << 4);

  // Post stages: sign fix, the P8 and P9 terms and the final sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      ps[1] <= dside[DIV_STAGES];
      for (int i = 2; i <= POST_STAGES; i++) begin
        ps[i] <= ps[i-1];
      end
      p1_q  <= dneg[DIV_STAGES] ? 64'd0 - dn[DIV_STAGES] : dn[DIV_STAGES];
      p2_q  <= p1_q;
      p2_x  <= x_c;
      p2_l8 <= mul17_lo(p1_q, p8_17);
      p2_h8 <= mul17_hi(p1_q, p8_17);
      p3_q  <= p2_q;
      p3_x  <= p2_x;
      p3_v2 <= v2s_c;
      p3_l9 <= mul17_lo(p2_x, p9_17);
      p3_h9 <= mul17_hi(p2_x, p9_17);
      p4_q  <= p3_q;
      p4_v2 <= p3_v2;
      p4_m1 <= m1_c;
      p4_x  <= p3_x;
      p5_q  <= p4_q;
      p5_v2 <= p4_v2;
      p5_ll <= p4_m1[31:0] * p4_x[31:0];
      p5_cr <= 32'(p4_m1[31:0] * p4_x[63:32]) + 32'(p4_m1[63:32] * p4_x[31:0]);
      p6_q  <= p5_q;
      p6_v2 <= p5_v2;
      p6_m2 <= m2_c;
      p7_p  <= ps[6].invalid ? 32'd0 : res_c[31:0];
    end
  end

  assign temperature      = ps[POST_STAGES].temperature;
  assign fine_temperature = ps[POST_STAGES].fine;
  assign pressure         = p7_p;
  assign pressure_invalid = ps[POST_STAGES].invalid;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pressure_invalid) |-> (pressure == 32'd0))
    else $error("invalid pressure result is not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (v == $past(v)))
    else $error("back pipeline moved while stalled");

endmodule

### dv/tb.sv
// Testbench for pressure_temp_compensation: streams raw sensor records through the
// block and checks every compensated result against a behavioral predictor.
// Depends on ptc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import ptc_pkg::*;

  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] fine;
    logic [31:0] pressure;
    logic        invalid;
  } comp_result_t;

  typedef struct {
    logic [47:0]  raw;
    bit           known;
    comp_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  // Local copy of the calibration registers.
  logic [47:0] cal_temp;
  logic [63:0] cal_pa;
  logic [63:0] cal_pb;
  logic [15:0] cal_pc;

  comp_result_t pending_results[$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold;

  pressure_temp_compensation dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Compensates one raw record with the current calibration.
  function automatic comp_result_t compensate(input logic [47:0] raw);
    comp_result_t r;
    logic signed [31:0] adc_t, adc_p, t1, t2, t3, a, d, b, fine;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, num;
    logic [63:0] an, ad, q;
    adc_p = {12'd0, raw[7:0], raw[15:8], raw[23:20]};
    adc_t = {12'd0, raw[31:24], raw[39:32], raw[47:44]};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    a = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = (adc_t >>> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    fine = a + b;
    r.fine = fine;
    r.temperature = (fine * 5 + 128) >>> 8;
    p1 = {48'd0, cal_pa[15:0]};
    p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
    p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
    p4 = {{48{cal_pa[63]}}, cal_pa[63:48]};
    p5 = {{48{cal_pb[15]}}, cal_pb[15:0]};
    p6 = {{48{cal_pb[31]}}, cal_pb[31:16]};
    p7 = {{48{cal_pb[47]}}, cal_pb[47:32]};
    p8 = {{48{cal_pb[63]}}, cal_pb[63:48]};
    p9 = {{48{cal_pc[15]}}, cal_pc};
    v1 = 64'(fine) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    r.pressure = '0;
    r.invalid = 1'b0;
    if (v1 == 0) begin
      r.invalid = 1'b1;
    end else begin
      p = 64'sd1048576 - 64'(adc_p);
      num = ((p <<< 31) - v2) * 64'sd3125;
      // Division by magnitudes truncates toward zero and wraps like hardware.
      an = num[63] ? -num : num;
      ad = v1[63] ? -v1 : v1;
      q = an / ad;
      p = (num[63] != v1[63]) ? -q : q;
      v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      r.pressure = p[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_cal(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TEMP_CAL:    cal_temp = val[47:0];
      REG_PRESS_CAL_A: cal_pa = val;
      REG_PRESS_CAL_B: cal_pb = val;
      default:         cal_pc = val[15:0];
    endcase
  endtask

  // Offers one record and holds it until the transfer happens.
  task automatic send_record(input logic [47:0] raw);
    while (($urandom_range(99) < send_idle_pct)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= raw;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(compensate(raw));
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_raw();
    return {$urandom, 16'($urandom)};
  endfunction

  // Calibration near the usual device values, with random spread.
  task automatic typical_cal;
    write_cal(REG_TEMP_CAL, 64'({16'($urandom_range(0, 100)),
                                 16'($urandom_range(25000, 28000)),
                                 16'($urandom_range(26000, 29000))}));
    write_cal(REG_PRESS_CAL_A, {16'($urandom_range(2000, 8000)), 16'hF000 | 16'($urandom),
                                16'hD000 | 16'($urandom), 16'($urandom_range(30000, 40000))});
    write_cal(REG_PRESS_CAL_B, {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
    write_cal(REG_PRESS_CAL_C, 64'($urandom));
  endtask

  // Receiver: random stalls, a long hold-off on request, and checking.
  always @(posedge clk) begin
    comp_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[31:0] !== want.temperature)
            report_mismatch("temperature", m_tdata[31:0], want.temperature);
          if (m_tdata[63:32] !== want.fine)
            report_mismatch("fine_temperature", m_tdata[63:32], want.fine);
          if (m_tdata[95:64] !== want.pressure)
            report_mismatch("pressure", m_tdata[95:64], want.pressure);
          if (m_tuser[0] !== want.invalid)
            report_mismatch("pressure_invalid", 32'(m_tuser), 32'(want.invalid));
        end
      end
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #20ms;
    $display("[pressure_temp_compensation] ERROR");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    logic [47:0] dir_raw [6];
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_TEMP_CAL;
    cfg_data = '0;
    cal_temp = '0;
    cal_pa = '0;
    cal_pb = '0;
    cal_pc = '0;
    dir_raw = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'hF0_0000_F000_00, 48'h0F_FFFF_0FFF_FF,
                48'h55AA_55AA_55AA, 48'hAA55_AA55_AA55};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset all calibration is zero: fine is zero, divisor zero, flag set.
    row.known = 1'b1;
    row.res = '{temperature: 32'd0, fine: 32'd0, pressure: 32'd0, invalid: 1'b1};
    row.raw = 48'h0;             rows.push_back(row);
    row.raw = 48'hFFFF_FFFF_FFFF; rows.push_back(row);
    row.raw = 48'h0F00_000F_0000; rows.push_back(row);
    foreach (rows[i]) begin
      send_record(rows[i].raw);
      if (rows[i].known) pending_results[pending_results.size() - 1] = rows[i].res;
    end
    drain();

    // Directed records under typical, extreme and negative calibration.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) typical_cal();
      if (ph == 1) begin
        write_cal(REG_TEMP_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(REG_PRESS_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(REG_PRESS_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(REG_PRESS_CAL_C, 64'hFFFF);
      end
      if (ph == 2) begin
        write_cal(REG_TEMP_CAL, 64'h8000_8000_7FFF);
        write_cal(REG_PRESS_CAL_A, 64'h8000_8000_7FFF_FFFF);
        write_cal(REG_PRESS_CAL_B, 64'h7FFF_8000_7FFF_8000);
        write_cal(REG_PRESS_CAL_C, 64'h8000);
      end
      foreach (dir_raw[k]) send_record(dir_raw[k]);
      drain();
    end

    // Random records in three idling regimes, calibration changed between blocks.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 17 : 0;
      for (int blk = 0; blk < 5; blk++) begin
        if (blk % 2 == 0) typical_cal();
        else begin
          write_cal(REG_TEMP_CAL, {$urandom, $urandom});
          write_cal(REG_PRESS_CAL_A, {$urandom, $urandom});
          write_cal(REG_PRESS_CAL_B, {$urandom, $urandom});
          write_cal(REG_PRESS_CAL_C, 64'($urandom));
        end
        // One block per phase starts with a long receiver hold-off.
        if (blk == 2) recv_hold = 300;
        for (int n = 0; n < 108; n++) send_record(rand_raw());
        // Sender waits for every result before the next block.
        drain();
      end
    end

    if (errors == 0) begin
      $display("[pressure_temp_compensation] OK");
    end else begin
      $display("[pressure_temp_compensation] ERROR");
    end
    $finish;
  end
endmodule
